// ===== sv/segmented_hit_count_cache_policy_assert.svh =====
// Assertion macros used by the segmented hit count cache policy sequencer.
// Depends on nothing; users must provide clk and rst_n in scope.
`ifndef SEGMENTED_HIT_COUNT_CACHE_POLICY_ASSERT_SVH
`define SEGMENTED_HIT_COUNT_CACHE_POLICY_ASSERT_SVH
`ifndef SYNTHESIS
`define SHCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SHCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHCC_ASSERT_IMP(lbl, ante, cons, msg)
`define SHCC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/shcc_pkg.sv =====
// Shared types, defaults and register indexes for the segmented hit count
// cache policy. Depends on nothing.
package shcc_pkg;

  localparam int HOT_DEPTH_DEF   = 8;
  localparam int WARM_DEPTH_DEF  = 128;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [15:0] THRESHOLD_RST = 16'd10;
  localparam logic [15:0] PERIOD_RST    = 16'd200;
  localparam logic [3:0]  HOT_CAP_RST   = 4'd8;
  localparam logic [7:0]  WARM_CAP_RST  = 8'd120;

  localparam logic [1:0] REG_HOT_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_DECAY_PERIOD  = 2'd1;
  localparam logic [1:0] REG_HOT_CAPACITY  = 2'd2;
  localparam logic [1:0] REG_WARM_CAPACITY = 2'd3;

  typedef struct packed {
    logic [15:0] hot_threshold;
    logic [15:0] decay_period;
    logic [3:0]  hot_capacity;
    logic [7:0]  warm_capacity;
  } cfg_t;

  typedef struct packed {
    logic        was_hit;
    logic        hit_in_hot;
    logic [31:0] total_hit_count;
  } res_t;

endpackage

// ===== sv/segmented_hit_count_cache_policy.sv =====
// Segmented hit count cache policy: one request beat in, one result beat out.
// Each request searches the entries (hot back to front, then warm), bubbles
// the updated entry toward the front, shifts the warm list on a promotion,
// and on a decay scales every hot entry and inserts each demoted entry into
// warm, where it bubbles toward the front. Each list RAM has a single read
// port, so entries are read and moved one at a time, and a new request is
// accepted only while the sequencer is idle.
// No clearing pass is needed after reset.
module segmented_hit_count_cache_policy
  import shcc_pkg::*;
#(
  parameter int HOT_DEPTH   = HOT_DEPTH_DEF,
  parameter int WARM_DEPTH  = WARM_DEPTH_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int IN_W = ((KEY_WIDTH + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,   // request_key
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [39:0]     out_tdata,  // was_hit, hit_in_hot, total_hit_count
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  localparam int EW  = KEY_WIDTH + COUNT_WIDTH;
  localparam int HAW = (HOT_DEPTH > 1) ? $clog2(HOT_DEPTH) : 1;
  localparam int WAW = (WARM_DEPTH > 1) ? $clog2(WARM_DEPTH) : 1;

  cfg_t             cfg_r;
  res_t             res, out_r;
  logic             out_valid_r, res_valid, res_ready, idle, start;
  logic             hot_we, warm_we;
  logic [HAW-1:0]   hot_waddr, hot_raddr;
  logic [WAW-1:0]   warm_waddr, warm_raddr;
  logic [EW-1:0]    hot_wdata, hot_rdata, warm_wdata, warm_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hot_threshold <= THRESHOLD_RST;
      cfg_r.decay_period <= PERIOD_RST;
      cfg_r.hot_capacity <= HOT_CAP_RST;
      cfg_r.warm_capacity <= WARM_CAP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HOT_THRESHOLD: cfg_r.hot_threshold <= cfg_data;
        REG_DECAY_PERIOD:  cfg_r.decay_period <= cfg_data;
        REG_HOT_CAPACITY:  cfg_r.hot_capacity <= cfg_data[3:0];
        REG_WARM_CAPACITY: cfg_r.warm_capacity <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_tready = idle;
  assign start = in_tvalid && idle;

  // A finished result moves to the output register once that is free.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'b0, out_r.total_hit_count, out_r.hit_in_hot, out_r.was_hit};

  shcc_ram #(.WIDTH(EW), .DEPTH(HOT_DEPTH)) u_hot_ram (
    .clk     (clk),
    .wr_en   (hot_we),
    .wr_addr (hot_waddr),
    .wr_data (hot_wdata),
    .rd_addr (hot_raddr),
    .rd_data (hot_rdata)
  );

  shcc_ram #(.WIDTH(EW), .DEPTH(WARM_DEPTH)) u_warm_ram (
    .clk     (clk),
    .wr_en   (warm_we),
    .wr_addr (warm_waddr),
    .wr_data (warm_wdata),
    .rd_addr (warm_raddr),
    .rd_data (warm_rdata)
  );

  shcc_seq #(
    .HOT_DEPTH   (HOT_DEPTH),
    .WARM_DEPTH  (WARM_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .start_key  (in_tdata[KEY_WIDTH-1:0]),
    .idle       (idle),
    .cfg        (cfg_r),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res),
    .hot_we     (hot_we),
    .hot_waddr  (hot_waddr),
    .hot_wdata  (hot_wdata),
    .hot_raddr  (hot_raddr),
    .hot_rdata  (hot_rdata),
    .warm_we    (warm_we),
    .warm_waddr (warm_waddr),
    .warm_wdata (warm_wdata),
    .warm_raddr (warm_raddr),
    .warm_rdata (warm_rdata)
  );

endmodule

// ===== sv/shcc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module shcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/shcc_seq.sv =====
// Request sequencer: searches, bubbles, promotes and decays entries held in
// the hot and warm RAMs. Depends on shcc_pkg and the assertion header.
`include "segmented_hit_count_cache_policy_assert.svh"
module shcc_seq
  import shcc_pkg::*;
#(
  parameter int HOT_DEPTH   = HOT_DEPTH_DEF,
  parameter int WARM_DEPTH  = WARM_DEPTH_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int HAW = (HOT_DEPTH > 1) ? $clog2(HOT_DEPTH) : 1,
  parameter int WAW = (WARM_DEPTH > 1) ? $clog2(WARM_DEPTH) : 1,
  parameter int EW  = KEY_WIDTH + COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [KEY_WIDTH-1:0] start_key,
  output logic                 idle,
  input  cfg_t                 cfg,
  input  logic                 res_ready,
  output logic                 res_valid,
  output res_t                 res,
  output logic                 hot_we,
  output logic [HAW-1:0]       hot_waddr,
  output logic [EW-1:0]        hot_wdata,
  output logic [HAW-1:0]       hot_raddr,
  input  logic [EW-1:0]        hot_rdata,
  output logic                 warm_we,
  output logic [WAW-1:0]       warm_waddr,
  output logic [EW-1:0]        warm_wdata,
  output logic [WAW-1:0]       warm_raddr,
  input  logic [EW-1:0]        warm_rdata
);

  localparam int HFW = $clog2(HOT_DEPTH + 1);
  localparam int WFW = $clog2(WARM_DEPTH + 1);
  localparam int IW  = (HFW > WFW) ? HFW : WFW;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_HS_RD  = 5'd1;
  localparam logic [4:0] S_HS_CMP = 5'd2;
  localparam logic [4:0] S_WS_RD  = 5'd3;
  localparam logic [4:0] S_WS_CMP = 5'd4;
  localparam logic [4:0] S_INS    = 5'd5;
  localparam logic [4:0] S_EVICT  = 5'd6;
  localparam logic [4:0] S_BUB_RD = 5'd7;
  localparam logic [4:0] S_BUB_CMP = 5'd8;
  localparam logic [4:0] S_RET    = 5'd9;
  localparam logic [4:0] S_PR_CMP = 5'd10;
  localparam logic [4:0] S_SH_RD  = 5'd11;
  localparam logic [4:0] S_SH_WR  = 5'd12;
  localparam logic [4:0] S_DEC_CHK = 5'd13;
  localparam logic [4:0] S_DEC_RD = 5'd14;
  localparam logic [4:0] S_DEC_WR = 5'd15;
  localparam logic [4:0] S_DEM_RD = 5'd16;
  localparam logic [4:0] S_DEM_LD = 5'd17;
  localparam logic [4:0] S_DONE   = 5'd18;

  localparam logic LST_WARM = 1'b0;
  localparam logic LST_HOT  = 1'b1;

  localparam logic [1:0] RET_LOOKUP = 2'd0;
  localparam logic [1:0] RET_PROMO  = 2'd1;
  localparam logic [1:0] RET_EVICT  = 2'd2;
  localparam logic [1:0] RET_DEMOTE = 2'd3;

  logic [4:0]             state_r, state_nxt;
  logic [IW-1:0]          hfill_r, hfill_nxt, wfill_r, wfill_nxt;
  logic [15:0]            tick_r, tick_nxt;
  logic [31:0]            hits_r, hits_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [KEY_WIDTH-1:0]   ck_r, ck_nxt, ek_r, ek_nxt;
  logic [COUNT_WIDTH-1:0] cc_r, cc_nxt, ec_r, ec_nxt;
  logic                   have_ev_r, have_ev_nxt;
  logic                   lst_r, lst_nxt;
  logic [1:0]             ret_r, ret_nxt;
  logic [IW-1:0]          idx_r, idx_nxt, pos_r, pos_nxt;
  logic [IW-1:0]          keep_r, keep_nxt, dem_end_r, dem_end_nxt;
  logic                   hit_r, hit_nxt, inhot_r, inhot_nxt;

  logic [IW-1:0]          rd_addr, wr_addr, hcap, wcap;
  logic [IW-1:0]          hlast, wlast, posm1, idxm1, idxp1, keep_n, dem_last;
  logic                   wr_en, wr_lst;
  logic [EW-1:0]          wr_data, d_lst;
  logic [KEY_WIDTH-1:0]   hk, wk;
  logic [COUNT_WIDTH-1:0] hc, wc, dc, hc_inc, wc_inc, c3;
  logic [COUNT_WIDTH+1:0] c3w;
  logic [16:0]            tick1;
  logic [31:0]            hits_inc;

  assign hk = hot_rdata[EW-1:COUNT_WIDTH];
  assign hc = hot_rdata[COUNT_WIDTH-1:0];
  assign wk = warm_rdata[EW-1:COUNT_WIDTH];
  assign wc = warm_rdata[COUNT_WIDTH-1:0];
  assign d_lst = (lst_r == LST_HOT) ? hot_rdata : warm_rdata;
  assign dc = d_lst[COUNT_WIDTH-1:0];
  assign hc_inc = (hc == {COUNT_WIDTH{1'b1}}) ? hc : hc + COUNT_WIDTH'(1);
  assign wc_inc = (wc == {COUNT_WIDTH{1'b1}}) ? wc : wc + COUNT_WIDTH'(1);
  assign hits_inc = (hits_r == 32'hFFFF_FFFF) ? hits_r : hits_r + 32'd1;
  // Scaling by 3/4 keeps the hot list in descending order, so the demoted
  // entries always form a tail of the list.
  assign c3w = ({2'b00, hc} << 1) + {2'b00, hc};
  assign c3 = c3w[COUNT_WIDTH+1:2];
  assign keep_n = keep_r + IW'(32'(c3) >= 32'(cfg.hot_threshold));
  assign tick1 = {1'b0, tick_r} + 17'd1;

  assign hlast = hfill_r - IW'(1);
  assign wlast = wfill_r - IW'(1);
  assign posm1 = pos_r - IW'(1);
  assign idxm1 = idx_r - IW'(1);
  assign idxp1 = idx_r + IW'(1);
  assign dem_last = dem_end_r - IW'(1);

  always_comb begin
    if (cfg.hot_capacity == 4'd0) begin
      hcap = IW'(1);
    end else if (32'(cfg.hot_capacity) > HOT_DEPTH) begin
      hcap = IW'(HOT_DEPTH);
    end else begin
      hcap = IW'(cfg.hot_capacity);
    end
    if (cfg.warm_capacity == 8'd0) begin
      wcap = IW'(1);
    end else if (32'(cfg.warm_capacity) > WARM_DEPTH) begin
      wcap = IW'(WARM_DEPTH);
    end else begin
      wcap = IW'(cfg.warm_capacity);
    end
  end

  always_comb begin
    state_nxt = state_r;
    hfill_nxt = hfill_r;
    wfill_nxt = wfill_r;
    tick_nxt = tick_r;
    hits_nxt = hits_r;
    key_nxt = key_r;
    ck_nxt = ck_r;
    cc_nxt = cc_r;
    ek_nxt = ek_r;
    ec_nxt = ec_r;
    have_ev_nxt = have_ev_r;
    lst_nxt = lst_r;
    ret_nxt = ret_r;
    idx_nxt = idx_r;
    pos_nxt = pos_r;
    keep_nxt = keep_r;
    dem_end_nxt = dem_end_r;
    hit_nxt = hit_r;
    inhot_nxt = inhot_r;
    rd_addr = idx_r;
    wr_en = 1'b0;
    wr_lst = lst_r;
    wr_addr = pos_r;
    wr_data = {ck_r, cc_r};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt = start_key;
          hit_nxt = 1'b0;
          inhot_nxt = 1'b0;
          if (hfill_r != '0) begin
            idx_nxt = hlast;
            state_nxt = S_HS_RD;
          end else if (wfill_r != '0) begin
            idx_nxt = wlast;
            state_nxt = S_WS_RD;
          end else begin
            ck_nxt = start_key;
            cc_nxt = '0;
            lst_nxt = LST_WARM;
            ret_nxt = RET_LOOKUP;
            state_nxt = S_INS;
          end
        end
      end
      S_HS_RD: state_nxt = S_HS_CMP;
      S_HS_CMP: begin
        if (hk == key_r) begin
          ck_nxt = key_r;
          cc_nxt = hc_inc;
          pos_nxt = idx_r;
          lst_nxt = LST_HOT;
          ret_nxt = RET_LOOKUP;
          hit_nxt = 1'b1;
          inhot_nxt = 1'b1;
          hits_nxt = hits_inc;
          state_nxt = S_BUB_RD;
        end else if (idx_r != '0) begin
          idx_nxt = idxm1;
          state_nxt = S_HS_RD;
        end else if (wfill_r != '0) begin
          idx_nxt = wlast;
          state_nxt = S_WS_RD;
        end else begin
          ck_nxt = key_r;
          cc_nxt = '0;
          lst_nxt = LST_WARM;
          ret_nxt = RET_LOOKUP;
          state_nxt = S_INS;
        end
      end
      S_WS_RD: state_nxt = S_WS_CMP;
      S_WS_CMP: begin
        if (wk == key_r) begin
          ck_nxt = key_r;
          cc_nxt = wc_inc;
          pos_nxt = idx_r;
          lst_nxt = LST_WARM;
          ret_nxt = RET_LOOKUP;
          hit_nxt = 1'b1;
          hits_nxt = hits_inc;
          state_nxt = S_BUB_RD;
        end else if (idx_r != '0) begin
          idx_nxt = idxm1;
          state_nxt = S_WS_RD;
        end else begin
          ck_nxt = key_r;
          cc_nxt = '0;
          lst_nxt = LST_WARM;
          ret_nxt = RET_LOOKUP;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        if (lst_r == LST_HOT) begin
          if (hfill_r >= hcap) begin
            rd_addr = hlast;
            state_nxt = S_EVICT;
          end else begin
            pos_nxt = hfill_r;
            hfill_nxt = hfill_r + IW'(1);
            state_nxt = S_BUB_RD;
          end
        end else begin
          if (wfill_r >= wcap) begin
            pos_nxt = wlast;
          end else begin
            pos_nxt = wfill_r;
            wfill_nxt = wfill_r + IW'(1);
          end
          state_nxt = S_BUB_RD;
        end
      end
      S_EVICT: begin
        // The last hot entry is replaced and later goes back to warm.
        ek_nxt = hk;
        ec_nxt = hc;
        have_ev_nxt = 1'b1;
        pos_nxt = hlast;
        state_nxt = S_BUB_RD;
      end
      S_BUB_RD: begin
        if (pos_r == '0) begin
          wr_en = 1'b1;
          state_nxt = S_RET;
        end else begin
          rd_addr = posm1;
          state_nxt = S_BUB_CMP;
        end
      end
      S_BUB_CMP: begin
        wr_en = 1'b1;
        if (cc_r >= dc) begin
          wr_data = d_lst;
          pos_nxt = posm1;
          state_nxt = S_BUB_RD;
        end else begin
          state_nxt = S_RET;
        end
      end
      S_RET: begin
        unique case (ret_r)
          RET_LOOKUP: begin
            rd_addr = '0;
            state_nxt = (wfill_r != '0) ? S_PR_CMP : S_DEC_CHK;
          end
          RET_PROMO: begin
            if (have_ev_r) begin
              ck_nxt = ek_r;
              cc_nxt = ec_r;
              have_ev_nxt = 1'b0;
              lst_nxt = LST_WARM;
              ret_nxt = RET_EVICT;
              state_nxt = S_INS;
            end else begin
              state_nxt = S_DEC_CHK;
            end
          end
          RET_EVICT: state_nxt = S_DEC_CHK;
          RET_DEMOTE: begin
            if (idx_r == dem_last) begin
              state_nxt = S_DONE;
            end else begin
              idx_nxt = idxp1;
              state_nxt = S_DEM_RD;
            end
          end
          default: state_nxt = S_DEC_CHK;
        endcase
      end
      S_PR_CMP: begin
        if (32'(wc) >= 32'(cfg.hot_threshold)) begin
          ck_nxt = wk;
          cc_nxt = wc;
          have_ev_nxt = 1'b0;
          if (wfill_r == IW'(1)) begin
            wfill_nxt = '0;
            lst_nxt = LST_HOT;
            ret_nxt = RET_PROMO;
            state_nxt = S_INS;
          end else begin
            idx_nxt = IW'(1);
            state_nxt = S_SH_RD;
          end
        end else begin
          state_nxt = S_DEC_CHK;
        end
      end
      S_SH_RD: state_nxt = S_SH_WR;
      S_SH_WR: begin
        wr_en = 1'b1;
        wr_lst = LST_WARM;
        wr_addr = idxm1;
        wr_data = warm_rdata;
        if (idx_r == wlast) begin
          wfill_nxt = wlast;
          lst_nxt = LST_HOT;
          ret_nxt = RET_PROMO;
          state_nxt = S_INS;
        end else begin
          idx_nxt = idxp1;
          state_nxt = S_SH_RD;
        end
      end
      S_DEC_CHK: begin
        if (tick1 >= {1'b0, cfg.decay_period}) begin
          tick_nxt = '0;
          idx_nxt = '0;
          keep_nxt = '0;
          state_nxt = (hfill_r != '0) ? S_DEC_RD : S_DONE;
        end else begin
          tick_nxt = tick1[15:0];
          state_nxt = S_DONE;
        end
      end
      S_DEC_RD: state_nxt = S_DEC_WR;
      S_DEC_WR: begin
        wr_en = 1'b1;
        wr_lst = LST_HOT;
        wr_addr = idx_r;
        wr_data = {hk, c3};
        keep_nxt = keep_n;
        if (idx_r == hlast) begin
          dem_end_nxt = hfill_r;
          hfill_nxt = keep_n;
          idx_nxt = keep_n;
          state_nxt = (keep_n == hfill_r) ? S_DONE : S_DEM_RD;
        end else begin
          idx_nxt = idxp1;
          state_nxt = S_DEC_RD;
        end
      end
      S_DEM_RD: state_nxt = S_DEM_LD;
      S_DEM_LD: begin
        ck_nxt = hk;
        cc_nxt = hc;
        lst_nxt = LST_WARM;
        ret_nxt = RET_DEMOTE;
        state_nxt = S_INS;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hfill_r <= '0;
      wfill_r <= '0;
      tick_r <= '0;
      hits_r <= '0;
    end else begin
      state_r <= state_nxt;
      hfill_r <= hfill_nxt;
      wfill_r <= wfill_nxt;
      tick_r <= tick_nxt;
      hits_r <= hits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    ck_r <= ck_nxt;
    cc_r <= cc_nxt;
    ek_r <= ek_nxt;
    ec_r <= ec_nxt;
    have_ev_r <= have_ev_nxt;
    lst_r <= lst_nxt;
    ret_r <= ret_nxt;
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    keep_r <= keep_nxt;
    dem_end_r <= dem_end_nxt;
    hit_r <= hit_nxt;
    inhot_r <= inhot_nxt;
  end

  assign hot_raddr = rd_addr[HAW-1:0];
  assign warm_raddr = rd_addr[WAW-1:0];
  assign hot_we = wr_en && (wr_lst == LST_HOT);
  assign warm_we = wr_en && (wr_lst == LST_WARM);
  assign hot_waddr = wr_addr[HAW-1:0];
  assign warm_waddr = wr_addr[WAW-1:0];
  assign hot_wdata = wr_data;
  assign warm_wdata = wr_data;

  assign idle = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.was_hit = hit_r;
  assign res.hit_in_hot = inhot_r;
  assign res.total_hit_count = hits_r;

  `SHCC_ASSERT_IMP(a_hot_fill_max, 1'b1, hfill_r <= IW'(HOT_DEPTH), "hot fill above depth")
  `SHCC_ASSERT_IMP(a_warm_fill_max, 1'b1, wfill_r <= IW'(WARM_DEPTH), "warm fill above depth")
  `SHCC_ASSERT_IMP(a_one_write, 1'b1, !(hot_we && warm_we), "both lists written at once")
  `SHCC_ASSERT_NXT(a_start_busy, start && state_r == S_IDLE, state_r != S_IDLE, "start lost")

endmodule
